FILE: hdl/abkf_pkg.sv
// shared widths and fixed-point helpers for the angle/bias kalman filter
package abkf_pkg;

    localparam int MUL_W  = 36;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 34;
    localparam int GAIN_FRAC = 30;
    localparam int DT_FRAC = 16;

    localparam logic [31:0] ANGLE_NOISE_RST   = 32'd268435;
    localparam logic [31:0] BIAS_NOISE_RST    = 32'd805306;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd268435;

    localparam logic [2:0] REG_ANGLE_NOISE   = 3'd0;
    localparam logic [2:0] REG_BIAS_NOISE    = 3'd1;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'd2;
    localparam logic [2:0] REG_FULL_PREDICT  = 3'd3;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [63:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = (p + (PROD_W'(1) <<< (DT_FRAC - 1))) >>> DT_FRAC;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] rnd30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = (p + (PROD_W'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        return v[63:0];
    endfunction

endpackage

FILE: hdl/abkf_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
module abkf_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [abkf_pkg::MUL_W-1:0]     op_a,
    input  logic signed [abkf_pkg::MUL_W-1:0]     op_b,
    output logic                                  done,
    output logic signed [abkf_pkg::PROD_W-1:0]    prod
);
    import abkf_pkg::*;

    logic signed [MUL_W:0]   hi_reg;
    logic [MUL_W-1:0]        lo_reg;
    logic signed [MUL_W-1:0] mcand_reg;
    logic [5:0]              cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [MUL_W:0]   addend;
    logic signed [MUL_W:0]   sum;
    logic                    last_bit;

    assign last_bit = (cnt_reg == 6'(MUL_W - 1));

    always_comb begin
        addend = '0;
        if (lo_reg[0]) begin
            // the sign bit of the multiplier carries negative weight
            addend = last_bit ? -{mcand_reg[MUL_W-1], mcand_reg}
                              : {mcand_reg[MUL_W-1], mcand_reg};
        end
        sum = hi_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                hi_reg    <= '0;
                lo_reg    <= op_b;
                mcand_reg <= op_a;
            end else if (busy_reg) begin
                hi_reg  <= sum >>> 1;
                lo_reg  <= {sum[0], lo_reg[MUL_W-1:1]};
                cnt_reg <= cnt_reg + 6'd1;
                if (last_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[MUL_W-1:0], lo_reg};

endmodule

FILE: hdl/abkf_div.sv
// restoring divider, one quotient bit per cycle
module abkf_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [abkf_pkg::DIV_NUM_W-1:0]     num,
    input  logic [abkf_pkg::DIV_DEN_W-1:0]     den,
    output logic                               done,
    output logic [abkf_pkg::DIV_NUM_W-1:0]     quo
);
    import abkf_pkg::*;

    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg[DIV_DEN_W-1:0], num_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
                num_reg <= {num_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

FILE: hdl/angle_bias_kalman_filter.sv
// two-state kalman filter for angle and gyro bias, sequenced over a serial mul and div
//
//  channel  | direction | payload
//  s_*      | in        | s_tdata: measured_angle, measured_rate, time_step
//  m_*      | out       | m_tdata: angle_estimate, bias_estimate
//  cfg_*    | in        | write-only noise and predict-mode registers
//
// each item runs ten products on the bit-serial multiplier (36 bits, each product with
// launch and done) and two gains on the restoring divider (62 bits), between the accept
// of the item and the load of m_tdata
// when the innovation variance is not positive the divider is skipped
// s_tready is high only while no item is in work; reset is synchronous and zeroes the state
// a result waits in the output register until taken; the next item may enter while it waits
module angle_bias_kalman_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // measured_angle[31:0], measured_rate[63:32], time_step[79:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // angle_estimate[31:0], bias_estimate[63:32]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import abkf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRED, ST_DTBB, ST_AA, ST_BB, ST_GAIN0, ST_GAIN1,
        ST_ANG, ST_BIAS, ST_UAA, ST_UAB, ST_UBA, ST_UBB, ST_OUT
    } state_t;

    state_t state_reg;
    logic   launched_reg;

    logic [31:0] angle_noise_reg, bias_noise_reg, measure_noise_reg;
    logic        full_predict_reg;

    logic signed [31:0] ang_reg, bias_reg, caa_reg, cab_reg, cba_reg, cbb_reg;
    logic signed [31:0] meas_reg, rate_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] pred_reg, a_reg, b_reg, c_reg, d_reg, k0_reg, k1_reg, y_reg;
    logic signed [MUL_W-1:0] dtbb_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b, term;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     mul_start, mul_done;
    logic [DIV_NUM_W-1:0]     div_num, div_quo;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_start, div_done;
    logic signed [DIV_DEN_W-1:0] s_var;
    logic signed [63:0]       r16, r30;
    logic signed [31:0]       div_src;
    logic [31:0]              div_mag;
    logic signed [63:0]       k_wide;
    logic                     is_mul_state, is_div_state;
    logic                     out_load;

    assign is_div_state = (state_reg == ST_GAIN0) || (state_reg == ST_GAIN1);
    assign is_mul_state = (state_reg != ST_IDLE) && (state_reg != ST_OUT) && !is_div_state;
    assign mul_start = is_mul_state && !launched_reg;
    assign div_start = is_div_state && !launched_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign term = (full_predict_reg ? dtbb_reg : '0) - MUL_W'(cab_reg) - MUL_W'(cba_reg)
                  + $signed({4'd0, angle_noise_reg});
    assign s_var = DIV_DEN_W'(a_reg) + $signed({2'd0, measure_noise_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PRED: begin
                mul_a = MUL_W'(rate_reg) - MUL_W'(bias_reg);
                mul_b = $signed({20'd0, dt_reg});
            end
            ST_DTBB: begin
                mul_a = MUL_W'(cbb_reg);
                mul_b = $signed({20'd0, dt_reg});
            end
            ST_AA: begin
                mul_a = term;
                mul_b = $signed({20'd0, dt_reg});
            end
            ST_BB: begin
                mul_a = $signed({4'd0, bias_noise_reg});
                mul_b = $signed({20'd0, dt_reg});
            end
            ST_ANG: begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_BIAS: begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_UAA: begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(a_reg);
            end
            ST_UAB: begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(b_reg);
            end
            ST_UBA: begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(a_reg);
            end
            ST_UBB: begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(b_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // gain = value * 2^30 / s, truncated toward zero
    assign div_src = (state_reg == ST_GAIN1) ? c_reg : a_reg;
    assign div_mag = div_src[31] ? 32'(-{div_src[31], div_src}) : div_src;
    assign div_num = {div_mag, 30'd0};
    assign div_den = s_var;
    assign k_wide  = div_src[31] ? -$signed({2'd0, div_quo}) : $signed({2'd0, div_quo});

    assign r16 = rnd16(mul_prod);
    assign r30 = rnd30(mul_prod);

    abkf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            launched_reg      <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            full_predict_reg  <= 1'b1;
            ang_reg           <= '0;
            bias_reg          <= '0;
            caa_reg           <= '0;
            cab_reg           <= '0;
            cba_reg           <= '0;
            cbb_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_wdata;
                    REG_BIAS_NOISE:    bias_noise_reg    <= cfg_wdata;
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_wdata;
                    REG_FULL_PREDICT:  full_predict_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (mul_done || div_done) begin
                launched_reg <= 1'b0;
            end else if (mul_start || div_start) begin
                launched_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        meas_reg  <= s_tdata[31:0];
                        rate_reg  <= s_tdata[63:32];
                        dt_reg    <= s_tdata[79:64];
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED: if (mul_done) begin
                    pred_reg  <= sat32(64'(ang_reg) + r16);
                    state_reg <= ST_DTBB;
                end
                ST_DTBB: if (mul_done) begin
                    dtbb_reg  <= r16[MUL_W-1:0];
                    b_reg     <= sat32(64'(cab_reg) - r16);
                    c_reg     <= sat32(64'(cba_reg) - r16);
                    state_reg <= ST_AA;
                end
                ST_AA: if (mul_done) begin
                    a_reg     <= sat32(64'(caa_reg) + r16);
                    state_reg <= ST_BB;
                end
                ST_BB: if (mul_done) begin
                    d_reg <= sat32(64'(cbb_reg) + r16);
                    y_reg <= sat32(64'(meas_reg) - 64'(pred_reg));
                    // no gain when the innovation variance is not positive
                    if (s_var > 0) begin
                        state_reg <= ST_GAIN0;
                    end else begin
                        k0_reg    <= '0;
                        k1_reg    <= '0;
                        state_reg <= ST_ANG;
                    end
                end
                ST_GAIN0: if (div_done) begin
                    k0_reg    <= sat32(k_wide);
                    state_reg <= ST_GAIN1;
                end
                ST_GAIN1: if (div_done) begin
                    k1_reg    <= sat32(k_wide);
                    state_reg <= ST_ANG;
                end
                ST_ANG: if (mul_done) begin
                    ang_reg   <= sat32(64'(pred_reg) + r30);
                    state_reg <= ST_BIAS;
                end
                ST_BIAS: if (mul_done) begin
                    bias_reg  <= sat32(64'(bias_reg) + r30);
                    state_reg <= ST_UAA;
                end
                ST_UAA: if (mul_done) begin
                    caa_reg   <= sat32(64'(a_reg) - r30);
                    state_reg <= ST_UAB;
                end
                ST_UAB: if (mul_done) begin
                    cab_reg   <= sat32(64'(b_reg) - r30);
                    state_reg <= ST_UBA;
                end
                ST_UBA: if (mul_done) begin
                    cba_reg   <= sat32(64'(c_reg) - r30);
                    state_reg <= ST_UBB;
                end
                ST_UBB: if (mul_done) begin
                    cbb_reg   <= sat32(64'(d_reg) - r30);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= {bias_reg, ang_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice without work in between");

    a_mul_done_launched: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> launched_reg && is_mul_state)
        else $error("multiplier finished with no operation pending");

    a_div_done_launched: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> launched_reg && is_div_state)
        else $error("divider finished with no operation pending");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_done && div_done))
        else $error("both arithmetic units finished together");

endmodule

FILE: dv/abkf_checker.sv
// checker for the angle/bias kalman filter: predicts each result and compares
`timescale 1ns / 1ps
module abkf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import abkf_pkg::*;

    typedef struct packed {
        logic signed [31:0] bias;
        logic signed [31:0] angle;
    } estimate_t;

    estimate_t estimate_q[$];

    logic [31:0] angle_noise, bias_noise, measure_noise;
    logic        full_predict;
    longint      angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor((x + 2^(n-1)) / 2^n), arithmetic shift is floor for signed
    function automatic longint round_shift(longint x, int n);
        longint v;
        v = x + (64'sd1 <<< (n - 1));
        return v >>> n;
    endfunction

    task automatic filter_step(input logic [79:0] item);
        longint meas, rate, dt, dtbb, term, a, b, c, d, s, k0, k1, y, apred;
        meas  = longint'($signed(item[31:0]));
        rate  = longint'($signed(item[63:32]));
        dt    = longint'({1'b0, item[79:64]});
        apred = clamp32(angle_st + round_shift(dt * (rate - bias_st), DT_FRAC));
        dtbb  = round_shift(dt * p_bb, DT_FRAC);
        term  = (full_predict ? dtbb : 0) - p_ab - p_ba + longint'({1'b0, angle_noise});
        a = clamp32(p_aa + round_shift(dt * term, DT_FRAC));
        b = clamp32(p_ab - dtbb);
        c = clamp32(p_ba - dtbb);
        d = clamp32(p_bb + round_shift(dt * longint'({1'b0, bias_noise}), DT_FRAC));
        s = a + longint'({1'b0, measure_noise});
        if (s > 0) begin
            k0 = clamp32((a * (64'sd1 <<< GAIN_FRAC)) / s);
            k1 = clamp32((c * (64'sd1 <<< GAIN_FRAC)) / s);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        y = clamp32(meas - apred);
        angle_st = clamp32(apred + round_shift(k0 * y, GAIN_FRAC));
        bias_st  = clamp32(bias_st + round_shift(k1 * y, GAIN_FRAC));
        p_aa = clamp32(a - round_shift(k0 * a, GAIN_FRAC));
        p_ab = clamp32(b - round_shift(k0 * b, GAIN_FRAC));
        p_ba = clamp32(c - round_shift(k1 * a, GAIN_FRAC));
        p_bb = clamp32(d - round_shift(k1 * b, GAIN_FRAC));
        estimate_q.push_back(estimate_t'({bias_st[31:0], angle_st[31:0]}));
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        estimate_t want;
        if (!aresetn) begin
            angle_noise   <= ANGLE_NOISE_RST;
            bias_noise    <= BIAS_NOISE_RST;
            measure_noise <= MEASURE_NOISE_RST;
            full_predict  <= 1'b1;
            angle_st = 0; bias_st = 0;
            p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
            estimate_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ANGLE_NOISE:   angle_noise   <= cfg_wdata;
                    REG_BIAS_NOISE:    bias_noise    <= cfg_wdata;
                    REG_MEASURE_NOISE: measure_noise <= cfg_wdata;
                    REG_FULL_PREDICT:  full_predict  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (estimate_q.size() == 0) begin
                    report("unexpected item", m_tdata[31:0], 32'h0);
                end else begin
                    want = estimate_q.pop_front();
                    if (m_tdata[31:0] !== want.angle) report("angle", m_tdata[31:0], want.angle);
                    if (m_tdata[63:32] !== want.bias) report("bias", m_tdata[63:32], want.bias);
                end
            end
            if (s_tvalid && s_tready) filter_step(s_tdata);
        end
        pending = estimate_q.size();
    end

endmodule

FILE: dv/tb.sv
// testbench top for the angle/bias kalman filter: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb;
    import abkf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [79:0] s_tdata;
    logic [63:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    int          fail_count, pending, idle_cycles;
    bit          calm;

    angle_bias_kalman_filter i_dut (.*);
    abkf_checker i_chk (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // random idling on the result side, none during calm stretches
    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 8);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL angle_bias_kalman_filter");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_item(input logic [31:0] meas, input logic [31:0] rate,
                             input logic [15:0] dt);
        while (!calm && $urandom_range(99) < 8) @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {dt, rate, meas};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(65536 * 20) - 65536 * 10;
            default: return $urandom_range(4000) - 2000;
        endcase
    endfunction

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            logic [15:0] dt;
            dt = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1000));
            send_item(rand_word($urandom_range(5) == 0 ? 0 : 1),
                      rand_word($urandom_range(2)), dt);
        end
    endtask

    initial begin
        aresetn = 0; s_tvalid = 0; s_tdata = '0;
        cfg_wr_en = 0; cfg_addr = '0; cfg_wdata = '0; calm = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: field extremes, zero time step, full scale jumps
        send_item(32'h0, 32'h0, 16'h0);
        send_item(32'h7fffffff, 32'h7fffffff, 16'hffff);
        send_item(32'h80000000, 32'h80000000, 16'hffff);
        send_item(32'h7fffffff, 32'h80000000, 16'h0);
        send_item(32'h80000000, 32'h7fffffff, 16'h1);
        send_item(32'h00010000, 32'h00008000, 16'd655);
        send_item(32'hffff0000, 32'hfffe0000, 16'h8000);
        send_item(32'h55555555, 32'haaaaaaaa, 16'h5555);
        send_item(32'haaaaaaaa, 32'h55555555, 16'haaaa);
        drain();

        // zero measurement noise with no process noise
        write_reg(REG_MEASURE_NOISE, 32'h0);
        write_reg(REG_ANGLE_NOISE, 32'h0);
        write_reg(REG_BIAS_NOISE, 32'h0);
        write_reg(3'd5, 32'hffffffff);
        send_item(32'h00100000, 32'h00010000, 16'h0);
        send_item(32'h00200000, 32'h00010000, 16'd100);
        drain();

        // huge noise terms drive covariances and gains into saturation
        write_reg(REG_ANGLE_NOISE, 32'hffffffff);
        write_reg(REG_BIAS_NOISE, 32'hffffffff);
        write_reg(REG_MEASURE_NOISE, 32'h1);
        write_reg(REG_FULL_PREDICT, 32'h0);
        send_item(32'h7fffffff, 32'h80000000, 16'hffff);
        send_item(32'h80000000, 32'h7fffffff, 16'hffff);
        send_item(32'h12345678, 32'h87654321, 16'h1234);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
                    write_reg(REG_BIAS_NOISE, BIAS_NOISE_RST);
                    write_reg(REG_MEASURE_NOISE, MEASURE_NOISE_RST);
                    write_reg(REG_FULL_PREDICT, 32'h1);
                end
                1: write_reg(REG_FULL_PREDICT, 32'h0);
                2: write_reg(REG_MEASURE_NOISE, 32'hffffffff);
                3: begin
                    write_reg(REG_MEASURE_NOISE, 32'h1);
                    write_reg(REG_FULL_PREDICT, 32'h1);
                end
                default: begin
                    write_reg(REG_ANGLE_NOISE, $urandom());
                    write_reg(REG_BIAS_NOISE, $urandom());
                    write_reg(REG_MEASURE_NOISE, $urandom_range(32'hffffffff, 1));
                    write_reg(REG_FULL_PREDICT, $urandom_range(1));
                end
            endcase
            calm = (ph == 2);
            random_items(155);
            drain();
        end

        if (fail_count == 0)
            $display("PASS angle_bias_kalman_filter");
        else
            $display("FAIL angle_bias_kalman_filter");
        $finish;
    end

endmodule
